[design/pmtc_pkg.sv]
// ----------------------------------------------------------------------------
// pmtc_pkg: shared types and codes
// Entry layout of the hit store, register set, compare unit flags and the
// result kind codes used across the coincidence pairing block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmtc_pkg;

	// one stored hit
	typedef struct packed {
		logic [5:0]         bar;
		logic signed [15:0] tm;
		logic [15:0]        energy;
	} entry_t;

	// configuration registers
	typedef struct packed {
		logic [15:0] cut;
		logic [15:0] thr;
		logic [5:0]  short_lo;
		logic [5:0]  short_hi;
	} cfg_t;

	// flags from the shared compare unit
	typedef struct packed {
		logic pair_hit;
		logic match;
		logic a_hot;
	} cmp_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	// register indexes
	localparam logic [1:0] REG_CUT      = 2'd0;
	localparam logic [1:0] REG_THR      = 2'd1;
	localparam logic [1:0] REG_SHORT_LO = 2'd2;
	localparam logic [1:0] REG_SHORT_HI = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_PAIR  = 2'd1;
	localparam logic [1:0] KIND_NORTH = 2'd2;
	localparam logic [1:0] KIND_SOUTH = 2'd3;

	// most result words per event
	localparam int RESULT_LIMIT = 32;

endpackage

`default_nettype wire

[design/pmtc_cmp.sv]
// ----------------------------------------------------------------------------
// pmtc_cmp: shared compare unit
// Compares one primary entry against one entry of the opposite list: bar
// match on long bars, time window and energy thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module pmtc_cmp (
	input  pmtc_pkg::cfg_t   cfg,
	input  pmtc_pkg::entry_t ea,
	input  pmtc_pkg::entry_t eb,
	output pmtc_pkg::cmp_t   res
);
	import pmtc_pkg::*;

	logic signed [16:0] diff;
	logic [16:0]        adiff;
	logic               a_long;
	logic               bar_eq;
	logic               in_win;
	logic               b_hot;

	// time difference south minus north, magnitude
	assign diff  = {eb.tm[15], eb.tm} - {ea.tm[15], ea.tm};
	assign adiff = diff[16] ? 17'(-diff) : 17'(diff);
	assign in_win = adiff < {1'b0, cfg.cut};

	// short bars never pair
	assign a_long = (ea.bar < cfg.short_lo) || (ea.bar > cfg.short_hi);
	assign bar_eq = ea.bar == eb.bar;
	assign b_hot  = eb.energy > cfg.thr;

	assign res.a_hot    = ea.energy > cfg.thr;
	assign res.match    = a_long & bar_eq;
	assign res.pair_hit = a_long & bar_eq & in_win & (res.a_hot | b_hot);

endmodule

`default_nettype wire

[design/pmtc_seq.sv]
// ----------------------------------------------------------------------------
// pmtc_seq: end of event sequencer
// Walks both planes twice over the hit store: a counting pass that sizes
// the result list, then an emitting pass that fills the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pmtc_seq #(
	parameter int H      = 4,
	parameter int CNT_W  = 3,
	parameter int ADDR_W = 4
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [3:0][CNT_W-1:0]       cnt,
	input  wire                         ovf,
	input  pmtc_pkg::cfg_t              cfg,
	input  pmtc_pkg::entry_t            ent_a,
	input  pmtc_pkg::entry_t            ent_b,
	output logic [ADDR_W-1:0]           rd_addr_a,
	output logic [ADDR_W-1:0]           rd_addr_b,
	output pmtc_pkg::seq_stat_t         stat,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [1:0]                  kind,
	output logic                        out_plane,
	output logic [5:0]                  out_bar,
	output logic [15:0]                 north_energy,
	output logic signed [15:0]          north_time,
	output logic [15:0]                 south_energy,
	output logic signed [15:0]          south_time,
	output logic                        dropped,
	output logic                        last
);
	import pmtc_pkg::*;

	localparam int TOT_W = $clog2(2 * H * H + 4 * H + RESULT_LIMIT + 1);
	localparam int K_W   = $clog2(RESULT_LIMIT + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_EV   = 3'd3;
	localparam logic [2:0] ST_NONE = 3'd4;
	localparam logic [2:0] ST_END  = 3'd5;

	localparam logic [1:0] PH_PAIR  = 2'd0;
	localparam logic [1:0] PH_NORTH = 2'd1;
	localparam logic [1:0] PH_SOUTH = 2'd2;

	logic [2:0]       state_q;
	logic             pass_q;
	logic             plane_q;
	logic [1:0]       phase_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic             found_q;
	logic [TOT_W-1:0] total_q;
	logic [K_W-1:0]   k_q;

	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic             plane_out_q;
	logic [5:0]       bar_q;
	entry_t           north_q;
	entry_t           south_q;
	logic             dropped_q;
	logic             last_q;

	logic [1:0]       la;
	logic [1:0]       lb;
	logic [CNT_W-1:0] cnt_a;
	logic [CNT_W-1:0] cnt_b;
	logic             b_valid;
	logic             j_last;
	logic             i_lt;
	logic             match_b;
	logic             want;
	logic             emit_ok;
	logic             slot_free;
	logic             over;
	logic [K_W-1:0]   emit_n;
	logic             is_last;
	logic [1:0]       res_kind;
	entry_t           res_north;
	entry_t           res_south;
	cmp_t             cmp;

	// shared compare unit
	pmtc_cmp u_cmp (
		.cfg (cfg),
		.ea  (ent_a),
		.eb  (ent_b),
		.res (cmp)
	);

	// primary and opposite list of the current phase
	assign la    = {plane_q, phase_q == PH_SOUTH};
	assign lb    = {plane_q, phase_q != PH_SOUTH};
	assign cnt_a = cnt[la];
	assign cnt_b = cnt[lb];

	assign rd_addr_a = ADDR_W'(la) * ADDR_W'(H) + ADDR_W'(i_q);
	assign rd_addr_b = ADDR_W'(lb) * ADDR_W'(H) + ADDR_W'(j_q);

	// step decisions
	assign b_valid = cnt_b != '0;
	assign j_last  = !b_valid || ((j_q + CNT_W'(1)) == cnt_b);
	assign i_lt    = i_q < cnt_a;
	assign match_b = b_valid & cmp.match;
	assign want    = (phase_q == PH_PAIR) ? (b_valid & cmp.pair_hit)
		: (j_last & ~(found_q | match_b) & cmp.a_hot);

	assign slot_free = !out_valid_q || out_ready;
	assign emit_ok   = pass_q && want && (k_q < K_W'(RESULT_LIMIT));
	assign over      = total_q > TOT_W'(RESULT_LIMIT);
	assign emit_n    = over ? K_W'(RESULT_LIMIT) : total_q[K_W-1:0];
	assign is_last   = (k_q + K_W'(1)) == emit_n;

	// result word of the current step
	always_comb begin
		res_kind  = KIND_PAIR;
		res_north = ent_a;
		res_south = ent_b;
		case (phase_q)
			PH_NORTH: begin
				res_kind  = KIND_NORTH;
				res_south = '0;
			end
			PH_SOUTH: begin
				res_kind  = KIND_SOUTH;
				res_north = '0;
				res_south = ent_a;
			end
			default: begin
				res_kind = KIND_PAIR;
			end
		endcase
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
			plane_q <= 1'b0;
			phase_q <= PH_PAIR;
			i_q     <= '0;
			j_q     <= '0;
			found_q <= 1'b0;
			total_q <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHK;
						pass_q  <= 1'b0;
						plane_q <= 1'b0;
						phase_q <= PH_PAIR;
						i_q     <= '0;
						total_q <= '0;
						k_q     <= '0;
					end
				end
				ST_CHK: begin
					j_q     <= '0;
					found_q <= 1'b0;
					if (i_lt) begin
						state_q <= ST_RD;
					end else begin
						i_q <= '0;
						if (phase_q != PH_SOUTH) begin
							phase_q <= phase_q + 2'd1;
						end else begin
							phase_q <= PH_PAIR;
							plane_q <= ~plane_q;
							if (plane_q) begin
								if (!pass_q) begin
									pass_q <= 1'b1;
								end else begin
									state_q <= (total_q == '0) ? ST_NONE : ST_END;
								end
							end
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					if (!(emit_ok && !slot_free)) begin
						if (!pass_q && want) begin
							total_q <= total_q + TOT_W'(1);
						end
						if (emit_ok) begin
							k_q <= k_q + K_W'(1);
						end
						found_q <= found_q | match_b;
						if (j_last) begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= ST_CHK;
						end else begin
							j_q     <= j_q + CNT_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_NONE: begin
					if (slot_free) begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EV && emit_ok && slot_free)
				|| (state_q == ST_NONE && slot_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EV && emit_ok && slot_free) begin
			kind_q      <= res_kind;
			plane_out_q <= plane_q;
			bar_q       <= ent_a.bar;
			north_q     <= res_north;
			south_q     <= res_south;
			dropped_q   <= ovf | over;
			last_q      <= is_last;
		end else if (state_q == ST_NONE && slot_free) begin
			kind_q      <= KIND_NONE;
			plane_out_q <= 1'b0;
			bar_q       <= '0;
			north_q     <= '0;
			south_q     <= '0;
			dropped_q   <= ovf;
			last_q      <= 1'b1;
		end
	end

	assign stat.idle = state_q == ST_IDLE;
	assign stat.done = state_q == ST_END;

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign out_plane    = plane_out_q;
	assign out_bar      = bar_q;
	assign north_energy = north_q.energy;
	assign north_time   = north_q.tm;
	assign south_energy = south_q.energy;
	assign south_time   = south_q.tm;
	assign dropped      = dropped_q;
	assign last         = last_q;

endmodule

`default_nettype wire

[design/pmt_hit_coincidence_pairing.sv]
// ----------------------------------------------------------------------------
// pmt_hit_coincidence_pairing: double ended tube hit pairing
// Stores one event's complete hits in four lists by plane and tube end and,
// at end of event, pairs north and south hits on long bars, then emits the
// single ended hits above threshold.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------
//  in        in_valid / in_ready     mode plane pmt_end bar hit_time
//                                    hit_energy has_adc has_tdc
//  out       out_valid / out_ready   kind out_plane out_bar north_energy
//                                    north_time south_energy south_time
//                                    dropped last
//  cfg       cfg_valid / cfg_ready   cfg_index cfg_data
//
//  a hit word is taken straight into the store, back to back while idle.
//  end of event runs two walks (count, emit) over both planes; each walk
//  compares every primary entry with every opposite entry in turn, through
//  the single compare unit and the registered store read; then ST_END
//  closes the event, after ST_NONE when the event has no result.
//  in_ready is low during the walk; a full output register stalls the walk.
//  reset clears counts, overflow flag, sequencer and registers to defaults.
//
`default_nettype none

module pmt_hit_coincidence_pairing #(
	parameter int HITS_PER_LIST = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 mode,
	input  wire                 plane,
	input  wire                 pmt_end,
	input  wire  [5:0]          bar,
	input  wire  signed [15:0]  hit_time,
	input  wire  [15:0]         hit_energy,
	input  wire                 has_adc,
	input  wire                 has_tdc,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [1:0]          kind,
	output logic                out_plane,
	output logic [5:0]          out_bar,
	output logic [15:0]         north_energy,
	output logic signed [15:0]  north_time,
	output logic [15:0]         south_energy,
	output logic signed [15:0]  south_time,
	output logic                dropped,
	output logic                last,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [1:0]          cfg_index,
	input  wire  [15:0]         cfg_data
);
	import pmtc_pkg::*;

	localparam int DEPTH  = 4 * HITS_PER_LIST;
	localparam int CNT_W  = $clog2(HITS_PER_LIST + 1);
	localparam int ADDR_W = $clog2(DEPTH);

	cfg_t                  cfg_q;
	logic [3:0][CNT_W-1:0] cnt_q;
	logic                  ovf_q;
	entry_t                hit_mem_q [DEPTH];
	entry_t                rd_a_q;
	entry_t                rd_b_q;

	logic                  in_acc;
	logic                  start;
	logic                  hit_ok;
	logic [1:0]            wr_list;
	logic                  list_full;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	entry_t                wr_entry;
	logic [ADDR_W-1:0]     rd_addr_a;
	logic [ADDR_W-1:0]     rd_addr_b;
	seq_stat_t             stat;

	assign in_ready  = stat.idle;
	assign cfg_ready = 1'b1;

	// input word decode
	assign in_acc    = in_valid & in_ready;
	assign start     = in_acc & mode;
	assign hit_ok    = in_acc & ~mode & has_adc & has_tdc;
	assign wr_list   = {plane, pmt_end};
	assign list_full = cnt_q[wr_list] >= CNT_W'(HITS_PER_LIST);
	assign wr_en     = hit_ok & ~list_full;
	assign wr_addr   = ADDR_W'(wr_list) * ADDR_W'(HITS_PER_LIST)
		+ ADDR_W'(cnt_q[wr_list]);
	assign wr_entry  = '{bar: bar, tm: hit_time, energy: hit_energy};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cut      <= 16'd1075;
			cfg_q.thr      <= 16'd500;
			cfg_q.short_lo <= 6'd22;
			cfg_q.short_hi <= 6'd23;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CUT:      cfg_q.cut      <= cfg_data;
				REG_THR:      cfg_q.thr      <= cfg_data;
				REG_SHORT_LO: cfg_q.short_lo <= cfg_data[5:0];
				REG_SHORT_HI: cfg_q.short_hi <= cfg_data[5:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// list fill counts and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (stat.done) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (hit_ok) begin
			if (list_full) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q[wr_list] <= cnt_q[wr_list] + CNT_W'(1);
			end
		end
	end

	// hit store, one write port and two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hit_mem_q[wr_addr] <= wr_entry;
		end
		rd_a_q <= hit_mem_q[rd_addr_a];
		rd_b_q <= hit_mem_q[rd_addr_b];
	end

	// end of event sequencer
	pmtc_seq #(
		.H      (HITS_PER_LIST),
		.CNT_W  (CNT_W),
		.ADDR_W (ADDR_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cnt          (cnt_q),
		.ovf          (ovf_q),
		.cfg          (cfg_q),
		.ent_a        (rd_a_q),
		.ent_b        (rd_b_q),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.out_plane    (out_plane),
		.out_bar      (out_bar),
		.north_energy (north_energy),
		.north_time   (north_time),
		.south_energy (south_energy),
		.south_time   (south_time),
		.dropped      (dropped),
		.last         (last)
	);

	// lists are empty right after an event closes
	a_clear_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> (cnt_q == '0) && !ovf_q)
		else $error("hit lists not cleared after end of event");

	// a word that is not the last of its event keeps the block busy
	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("block idle while event words remain");

	// counts hold during the walk
	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !stat.done |=> $stable(cnt_q))
		else $error("list counts moved during the walk");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for pmt_hit_coincidence_pairing
// Sends events of tube hits and end-of-event words, keeps its own copy of the
// four hit lists and the register set, works out the paddle results of each
// event and checks every result word against them in order. Covers directed
// corner cases, register sweeps, random idling on both sides and back pressure.
// ----------------------------------------------------------------------------

module testbench;

	import pmtc_pkg::*;

	localparam int HITS          = 4;
	localparam int SETTLE_CYCLES = 400;
	localparam int LIMIT_CYCLES  = 400000;

	localparam logic MODE_HIT   = 1'b0;
	localparam logic MODE_CLOSE = 1'b1;
	localparam logic END_NORTH  = 1'b0;
	localparam logic END_SOUTH  = 1'b1;

	// one input word
	typedef struct packed {
		logic        mode;
		logic        plane;
		logic        pend;
		logic [5:0]  bar;
		logic [15:0] tm;
		logic [15:0] en;
		logic        adc;
		logic        tdc;
	} hit_word_t;

	// one paddle result word
	typedef struct packed {
		logic [1:0]  kind;
		logic        plane;
		logic [5:0]  bar;
		logic [15:0] ne;
		logic [15:0] nt;
		logic [15:0] se;
		logic [15:0] st;
		logic        dropped;
		logic        last;
	} paddle_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               mode = 1'b0;
	logic               plane = 1'b0;
	logic               pmt_end = 1'b0;
	logic [5:0]         bar = 6'd0;
	logic signed [15:0] hit_time = 16'sd0;
	logic [15:0]        hit_energy = 16'd0;
	logic               has_adc = 1'b0;
	logic               has_tdc = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         kind;
	logic               out_plane;
	logic [5:0]         out_bar;
	logic [15:0]        north_energy;
	logic signed [15:0] north_time;
	logic [15:0]        south_energy;
	logic signed [15:0] south_time;
	logic               dropped;
	logic               last;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = 2'd0;
	logic [15:0]        cfg_data = 16'd0;

	// mirror of the block: hit lists, fill counts, overflow flag, registers
	entry_t  hit_lists [4][HITS];
	int      list_fill [4] = '{0, 0, 0, 0};
	logic    lost_hit = 1'b0;
	cfg_t    model_cfg = '{cut: 16'd1075, thr: 16'd500, short_lo: 6'd22, short_hi: 6'd23};

	paddle_t paddle_due [$];
	paddle_t event_results [$];
	logic    results_clipped;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int words_sent = 0;
	int mismatches = 0;
	int cycles_run = 0;

	pmt_hit_coincidence_pairing #(
		.HITS_PER_LIST(HITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.plane(plane),
		.pmt_end(pmt_end),
		.bar(bar),
		.hit_time(hit_time),
		.hit_energy(hit_energy),
		.has_adc(has_adc),
		.has_tdc(has_tdc),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.out_plane(out_plane),
		.out_bar(out_bar),
		.north_energy(north_energy),
		.north_time(north_time),
		.south_energy(south_energy),
		.south_time(south_time),
		.dropped(dropped),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run >= LIMIT_CYCLES) begin
			$display("pmt_hit_coincidence_pairing regression: fail");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off counted down here
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic bar_is_long(input logic [5:0] b);
		return b < model_cfg.short_lo || b > model_cfg.short_hi;
	endfunction

	function automatic logic bar_listed(input int list, input logic [5:0] b);
		for (int k = 0; k < list_fill[list]; k++)
			if (hit_lists[list][k].bar == b)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void add_result(input logic [1:0] k, input logic pl, input logic [5:0] b,
			input logic [15:0] ne, input logic [15:0] nt, input logic [15:0] se,
			input logic [15:0] st);
		paddle_t r;
		if (event_results.size() >= RESULT_LIMIT)
			results_clipped = 1'b1;
		else begin
			r = '{k, pl, b, ne, nt, se, st, 1'b0, 1'b0};
			event_results = {event_results, r};
		end
	endfunction

	// end of event: pairs, then north-only, then south-only, per plane
	task automatic pair_event_hits();
		paddle_t r;
		int nl, sl, d;
		entry_t n, s;
		event_results.delete();
		results_clipped = 1'b0;
		for (int pl = 0; pl < 2; pl++) begin
			nl = 2 * pl;
			sl = nl + 1;
			for (int i = 0; i < list_fill[nl]; i++) begin
				n = hit_lists[nl][i];
				if (bar_is_long(n.bar)) begin
					for (int j = 0; j < list_fill[sl]; j++) begin
						s = hit_lists[sl][j];
						d = int'($signed(s.tm)) - int'($signed(n.tm));
						if (d < 0)
							d = -d;
						if (s.bar == n.bar && d < int'(model_cfg.cut) &&
								(n.energy > model_cfg.thr || s.energy > model_cfg.thr))
							add_result(KIND_PAIR, pl[0], n.bar, n.energy, n.tm, s.energy, s.tm);
					end
				end
			end
			for (int i = 0; i < list_fill[nl]; i++) begin
				n = hit_lists[nl][i];
				if (!(bar_is_long(n.bar) && bar_listed(sl, n.bar)) && n.energy > model_cfg.thr)
					add_result(KIND_NORTH, pl[0], n.bar, n.energy, n.tm, 16'd0, 16'd0);
			end
			for (int i = 0; i < list_fill[sl]; i++) begin
				s = hit_lists[sl][i];
				if (!(bar_is_long(s.bar) && bar_listed(nl, s.bar)) && s.energy > model_cfg.thr)
					add_result(KIND_SOUTH, pl[0], s.bar, 16'd0, 16'd0, s.energy, s.tm);
			end
		end
		if (event_results.size() == 0)
			add_result(KIND_NONE, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		foreach (event_results[k]) begin
			r = event_results[k];
			r.dropped = lost_hit || results_clipped;
			r.last = (k == event_results.size() - 1);
			paddle_due = {paddle_due, r};
		end
		list_fill = '{0, 0, 0, 0};
		lost_hit = 1'b0;
	endtask

	// accepted word: file the hit or close the event
	task automatic apply_word(input hit_word_t w);
		int list;
		if (w.mode == MODE_CLOSE) begin
			pair_event_hits();
		end else if (w.adc && w.tdc) begin
			list = int'({w.plane, w.pend});
			if (list_fill[list] >= HITS) begin
				lost_hit = 1'b1;
			end else begin
				hit_lists[list][list_fill[list]] = '{w.bar, w.tm, w.en};
				list_fill[list]++;
			end
		end
	endtask

	// send one word; entered and left at a falling edge
	task automatic send_word(input hit_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= w.mode;
		plane <= w.plane;
		pmt_end <= w.pend;
		bar <= w.bar;
		hit_time <= w.tm;
		hit_energy <= w.en;
		has_adc <= w.adc;
		has_tdc <= w.tdc;
		do
			@(posedge clk);
		while (!in_ready);
		apply_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic hit_word_t make_hit(input logic pl, input logic e, input logic [5:0] b,
			input int t, input int en);
		hit_word_t w;
		w = '{MODE_HIT, pl, e, b, t[15:0], en[15:0], 1'b1, 1'b1};
		return w;
	endfunction

	// end-of-event word, the other fields are don't care
	function automatic hit_word_t close_word();
		hit_word_t w;
		w.mode = MODE_CLOSE;
		w.plane = 1'($urandom_range(1));
		w.pend = 1'($urandom_range(1));
		w.bar = 6'($urandom_range(63));
		w.tm = 16'($urandom);
		w.en = 16'($urandom);
		w.adc = 1'($urandom_range(1));
		w.tdc = 1'($urandom_range(1));
		return w;
	endfunction

	// pause the input until every paddle result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (paddle_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_CUT:      model_cfg.cut = data;
			REG_THR:      model_cfg.thr = data;
			REG_SHORT_LO: model_cfg.short_lo = data[5:0];
			REG_SHORT_HI: model_cfg.short_hi = data[5:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// registers change only with the block idle
	task automatic set_config(input int cut, input int thr, input int lo, input int hi);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_CUT, cut[15:0]);
		write_reg(REG_THR, thr[15:0]);
		write_reg(REG_SHORT_LO, lo[15:0]);
		write_reg(REG_SHORT_HI, hi[15:0]);
		cfg_valid <= 1'b0;
	endtask

	// one random event: a burst of hits on a few bars, then end of event,
	// or now and then a single word of noise
	task automatic send_random_event();
		hit_word_t w;
		int nhits, span, base, t;
		logic [5:0] b0, b1, b2;
		if ($urandom_range(9) == 0) begin
			w = close_word();
			w.mode = 1'($urandom_range(1));
			send_word(w);
		end else begin
			nhits = ($urandom_range(7) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 7);
			b0 = 6'($urandom_range(63));
			b1 = 6'($urandom_range(63));
			b2 = $urandom_range(1) ? model_cfg.short_lo : 6'($urandom_range(63));
			span = (model_cfg.cut > 16'd30000) ? 30000 : int'(model_cfg.cut) + 4;
			base = int'($urandom_range(65535)) - 32768;
			repeat (nhits) begin
				w.mode = MODE_HIT;
				w.plane = 1'($urandom_range(1));
				w.pend = 1'($urandom_range(1));
				case ($urandom_range(2))
					0: w.bar = b0;
					1: w.bar = b1;
					default: w.bar = b2;
				endcase
				if ($urandom_range(7) == 0) begin
					w.tm = 16'($urandom);
				end else begin
					t = base + int'($urandom_range(2 * span)) - span;
					w.tm = t[15:0];
				end
				case ($urandom_range(2))
					0: w.en = model_cfg.thr + 16'($urandom_range(6)) - 16'd3;
					1: w.en = 16'($urandom);
					default: w.en = 16'($urandom_range(1500));
				endcase
				w.adc = ($urandom_range(9) != 0);
				w.tdc = ($urandom_range(9) != 0);
				send_word(w);
			end
			send_word(close_word());
		end
	endtask

	task automatic run_events(input int budget);
		int start;
		start = words_sent;
		while (words_sent - start < budget)
			send_random_event();
	endtask

	// directed corners with the reset register values
	task automatic test_directed_cases();
		hit_word_t w;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// empty event
		send_word(close_word());
		// plane 0: pair, short bar both ends, bar 0 at the field extremes
		send_word(make_hit(1'b0, END_NORTH, 6'd5, 100, 600));
		send_word(make_hit(1'b0, END_SOUTH, 6'd5, -900, 10));
		send_word(make_hit(1'b0, END_NORTH, 6'd22, 7, 700));
		send_word(make_hit(1'b0, END_SOUTH, 6'd22, 9, 800));
		send_word(make_hit(1'b0, END_NORTH, 6'd0, -32768, 65535));
		send_word(make_hit(1'b0, END_SOUTH, 6'd0, 32767, 0));
		// hits missing adc or tdc data are ignored
		w = make_hit(1'b0, END_SOUTH, 6'd9, 0, 900);
		w.adc = 1'b0;
		send_word(w);
		w.adc = 1'b1;
		w.tdc = 1'b0;
		send_word(w);
		// plane 1: time window edges and energy at threshold
		send_word(make_hit(1'b1, END_NORTH, 6'd63, 0, 501));
		send_word(make_hit(1'b1, END_SOUTH, 6'd63, 1074, 500));
		send_word(make_hit(1'b1, END_NORTH, 6'd30, 0, 900));
		send_word(make_hit(1'b1, END_SOUTH, 6'd30, -1075, 900));
		send_word(make_hit(1'b1, END_NORTH, 6'd40, 0, 500));
		send_word(close_word());
		// full list, last hit dropped and flagged
		for (int i = 0; i <= HITS; i++)
			send_word(make_hit(1'b1, END_SOUTH, 6'd7, i * 10, 1000));
		send_word(close_word());
	endtask

	task automatic test_random_traffic(input int budget, input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		run_events(budget);
	endtask

	// register sweep including the extremes and a swapped short range
	task automatic test_config_sweep();
		send_idle_pct = 10;
		recv_stall_pct = 10;
		set_config(0, 500, 22, 23);
		run_events(8);
		set_config(65535, 0, 40, 10);
		run_events(8);
		set_config(200, 65535, 1, 63);
		run_events(8);
		set_config(3000, 1000, 63, 63);
		run_events(8);
		set_config($urandom_range(65535), $urandom_range(2000), $urandom_range(1, 63),
			$urandom_range(1, 63));
		run_events(8);
		set_config(1075, 500, 22, 23);
		run_events(8);
	endtask

	// receiver holds off while the sender keeps going, then a full pause
	task automatic test_back_pressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_left = 1500;
		@(negedge clk);
		run_events(24);
		wait_drained();
		run_events(4);
	endtask

	task automatic note_mismatch(input string why, input paddle_t want, input paddle_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: want kind %0d plane %0d bar %0d n %0d/%0d s %0d/%0d drop %0d last %0d",
				why, want.kind, want.plane, want.bar, want.ne, $signed(want.nt), want.se,
				$signed(want.st), want.dropped, want.last,
				"\n  got kind %0d plane %0d bar %0d n %0d/%0d s %0d/%0d drop %0d last %0d",
				got.kind, got.plane, got.bar, got.ne, $signed(got.nt), got.se,
				$signed(got.st), got.dropped, got.last);
	endtask

	// compare each result word with the oldest one due
	always @(posedge clk) begin
		paddle_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind, out_plane, out_bar, north_energy, north_time, south_energy,
				south_time, dropped, last};
			if (paddle_due.size() == 0) begin
				note_mismatch("result word with none due", '0, got);
			end else begin
				want = paddle_due.pop_front();
				if (got.kind !== want.kind || got.plane !== want.plane ||
						got.bar !== want.bar || got.ne !== want.ne || got.nt !== want.nt ||
						got.se !== want.se || got.st !== want.st ||
						got.dropped !== want.dropped || got.last !== want.last)
					note_mismatch("result word mismatch", want, got);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_random_traffic(24, 0, 0);
		test_random_traffic(24, 77, 0);
		test_random_traffic(24, 0, 77);
		test_random_traffic(24, 10, 10);
		test_config_sweep();
		test_back_pressure();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		mismatches += paddle_due.size();
		if (mismatches == 0)
			$display("pmt_hit_coincidence_pairing regression: pass");
		else
			$display("pmt_hit_coincidence_pairing regression: fail");
		$finish;
	end

endmodule
